// ===== rtl/tlt_pkg.sv =====
// Shared widths, codes and types of the thread load tracker.
package tlt_pkg;

  localparam int unsigned TIME_W         = 64;
  localparam int unsigned FACTOR_W       = 32;
  localparam int unsigned SCALE_W        = 6;
  localparam int unsigned LOAD_W         = 11;
  localparam int unsigned REQ_W          = 2;
  localparam int unsigned RS_W           = 3;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned LOAD_SHIFT_DEF = 10;
  localparam int unsigned LOAD_MAX       = 2047;

  // Request codes carried by req_type.
  localparam logic [REQ_W-1:0] REQ_STATE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DECAY  = 2'd2;

  // Run states up to and including deferred count as runnable.
  localparam logic [RS_W-1:0] RS_DEFERRED    = 3'd2;
  localparam logic [RS_W-1:0] RS_INTERRUPTED = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_SCALE  = 2'd1;

  // Result of one pass of the serial accounting unit.
  typedef struct packed {
    logic              done;
    logic              err;
    logic [TIME_W-1:0] acc;
  } acct_res_t;

endpackage

// ===== rtl/tlt_acct.sv =====
// Bit-serial elapsed-time accounting: subtract the stamps and add to an accumulator.
module tlt_acct (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tlt_pkg::TIME_W-1:0] now_i,
  input  logic [tlt_pkg::TIME_W-1:0] last_i,
  input  logic [tlt_pkg::TIME_W-1:0] acc_i,
  output tlt_pkg::acct_res_t         res_o
);
  import tlt_pkg::*;

  localparam int unsigned CNT_W = $clog2(TIME_W);

  logic [TIME_W-1:0] now_q, last_q, acc_q, sum_q;
  logic              borrow_q, carry_q, busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              done_q, err_q;
  logic [TIME_W-1:0] res_acc_q;

  logic              a_bit, b_bit, c_bit, diff_bit, sum_bit, borrow_d, carry_d, last_bit;
  logic [TIME_W-1:0] sum_d;

  // One bit of the stamp difference and one bit of the accumulator sum per cycle.
  always_comb begin
    a_bit    = now_q[0];
    b_bit    = last_q[0];
    c_bit    = acc_q[0];
    diff_bit = a_bit ^ b_bit ^ borrow_q;
    borrow_d = (~a_bit & b_bit) | (~(a_bit ^ b_bit) & borrow_q);
    sum_bit  = c_bit ^ diff_bit ^ carry_q;
    carry_d  = (c_bit & diff_bit) | (carry_q & (c_bit ^ diff_bit));
    sum_d    = {sum_bit, sum_q[TIME_W-1:1]};
    last_bit = (cnt_q == CNT_W'(TIME_W - 1));
  end

  // Sequencing and the done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && last_bit;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_bit) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Operand shift registers and the saturated result.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      now_q    <= now_i;
      last_q   <= last_i;
      acc_q    <= acc_i;
      sum_q    <= '0;
      borrow_q <= 1'b0;
      carry_q  <= 1'b0;
    end else if (busy_q) begin
      now_q    <= now_q >> 1;
      last_q   <= last_q >> 1;
      acc_q    <= acc_q >> 1;
      sum_q    <= sum_d;
      borrow_q <= borrow_d;
      carry_q  <= carry_d;
      if (last_bit) begin
        err_q     <= borrow_d;
        res_acc_q <= carry_d ? '1 : sum_d;
      end
    end
  end

  assign res_o = {done_q, err_q, res_acc_q};

endmodule

// ===== rtl/tlt_div.sv =====
// Load ratio divider: one quotient bit per cycle by restoring division.
module tlt_div #(
  parameter int unsigned LOAD_SHIFT = tlt_pkg::LOAD_SHIFT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tlt_pkg::TIME_W-1:0] run_i,
  input  logic [tlt_pkg::TIME_W-1:0] idle_i,
  output logic                       done_o,
  output logic [tlt_pkg::LOAD_W-1:0] load_o
);
  import tlt_pkg::*;

  // The ratio never exceeds one, so the quotient has LOAD_SHIFT + 1 bits.
  localparam int unsigned Q_BITS = LOAD_SHIFT + 1;
  localparam int unsigned QW     = (Q_BITS > LOAD_W) ? Q_BITS : LOAD_W;
  localparam int unsigned CNT_W  = $clog2(LOAD_SHIFT + 2);
  localparam int unsigned DW     = TIME_W + 1;
  localparam int unsigned RW     = TIME_W + 2;

  logic [DW-1:0]    den_q;
  logic [RW-1:0]    rem_q;
  logic [QW-1:0]    quo_q;
  logic             zero_q, busy_q, setup_q, done_q;
  logic [CNT_W-1:0] cnt_q;

  logic             ge;
  logic [RW-1:0]    rem_sub;
  logic             last_it;

  // Compare and subtract the divisor once per cycle.
  always_comb begin
    ge      = (rem_q >= {1'b0, den_q});
    rem_sub = ge ? (rem_q - {1'b0, den_q}) : rem_q;
    last_it = (cnt_q == CNT_W'(LOAD_SHIFT));
  end

  // Sequencing: a setup step for the divisor sum, then the iterations.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      setup_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q  <= busy_q && last_it;
      setup_q <= start_i;
      if (setup_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_it) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Divisor, partial remainder and quotient.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= {1'b0, run_i} + {1'b0, idle_i};
      rem_q  <= {2'b00, run_i};
      quo_q  <= '0;
      zero_q <= (run_i == '0);
    end else if (busy_q) begin
      rem_q <= rem_sub << 1;
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign load_o = zero_q ? '0 :
                  (quo_q > QW'(LOAD_MAX)) ? LOAD_W'(LOAD_MAX) : quo_q[LOAD_W-1:0];

endmodule

// ===== rtl/tlt_decay.sv =====
// Decay unit: shift-and-add multiply of both accumulators, then a serial right shift.
module tlt_decay (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tlt_pkg::TIME_W-1:0]   run_i,
  input  logic [tlt_pkg::TIME_W-1:0]   idle_i,
  input  logic [tlt_pkg::FACTOR_W-1:0] factor_i,
  input  logic [tlt_pkg::SCALE_W-1:0]  scale_i,
  output logic                         done_o,
  output logic [tlt_pkg::TIME_W-1:0]   run_o,
  output logic [tlt_pkg::TIME_W-1:0]   idle_o
);
  import tlt_pkg::*;

  localparam int unsigned CNT_W = $clog2(FACTOR_W);

  typedef enum logic [1:0] {
    DC_IDLE,
    DC_MUL,
    DC_SHIFT
  } dc_state_e;

  dc_state_e           state_q;
  logic                done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [SCALE_W-1:0]  sc_q;
  logic [TIME_W-1:0]   a_q, b_q, pa_q, pb_q;
  logic [FACTOR_W-1:0] f_q;

  logic                mul_last;

  assign mul_last = (cnt_q == CNT_W'(FACTOR_W - 1));

  // Sequencer: one factor bit per cycle, then one shift step per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DC_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      sc_q    <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        DC_IDLE: begin
          if (start_i) begin
            state_q <= DC_MUL;
            cnt_q   <= '0;
            sc_q    <= scale_i;
          end
        end
        DC_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (mul_last) begin
            state_q <= DC_SHIFT;
          end
        end
        DC_SHIFT: begin
          if (sc_q == '0) begin
            state_q <= DC_IDLE;
            done_q  <= 1'b1;
          end else begin
            sc_q <= sc_q - 1'b1;
          end
        end
        default: state_q <= DC_IDLE;
      endcase
    end
  end

  // Both accumulators run side by side; products keep their low bits.
  always_ff @(posedge clk_i) begin
    if (start_i && state_q == DC_IDLE) begin
      a_q  <= run_i;
      b_q  <= idle_i;
      f_q  <= factor_i;
      pa_q <= '0;
      pb_q <= '0;
    end else if (state_q == DC_MUL) begin
      pa_q <= (pa_q << 1) + (f_q[FACTOR_W-1] ? a_q : '0);
      pb_q <= (pb_q << 1) + (f_q[FACTOR_W-1] ? b_q : '0);
      f_q  <= f_q << 1;
    end else if (state_q == DC_SHIFT && sc_q != '0) begin
      pa_q <= pa_q >> 1;
      pb_q <= pb_q >> 1;
    end
  end

  assign done_o = done_q;
  assign run_o  = pa_q;
  assign idle_o = pb_q;

endmodule

// ===== rtl/thread_load_tracker.sv =====
// Top level of the thread load tracker: request sequencing, state and result register.
//
// Tracks the load of one thread from runnable and not-runnable time.
// Input channel (in_valid_i/in_ready_o) carries one request item: a state
// change, a load update or a decay. Every item yields exactly one result item
// on the output channel (out_valid_o/out_ready_i): the stored load level and a
// flag for a timestamp that went backwards.
// Work per item, from acceptance to result:
//   state change: one pass of the bit-serial 64-bit accounting unit;
//   load update: the accounting pass, then one divider
//   iteration per quotient bit;
//   decay: one step per factor bit, then one per shift step;
//   an unknown request type goes straight to the result.
// One item is worked on at a time; the next is taken once the result has been
// moved to the output register, even while that result still waits.
// If the receiver stalls, a finished result waits in its state until the
// output register is free. Reset clears both accumulators and the last stamp,
// sets the run state to interrupted, the load to zero, decay_factor to 1 and
// decay_scale to 0. Configuration is to be written through cfg_we_i only while
// the block is idle; the block itself does not enforce this.
module thread_load_tracker #(
  parameter int unsigned LOAD_SHIFT = tlt_pkg::LOAD_SHIFT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tlt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tlt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tlt_pkg::REQ_W-1:0]      req_type_i,
  input  logic [tlt_pkg::TIME_W-1:0]     timestamp_i,
  input  logic [tlt_pkg::RS_W-1:0]       run_state_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tlt_pkg::LOAD_W-1:0]     load_level_o,
  output logic                           time_error_o
);
  import tlt_pkg::*;

  localparam int unsigned LOAD_LIMIT = (LOAD_SHIFT >= LOAD_W) ? LOAD_MAX : (1 << LOAD_SHIFT);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCT,
    ST_DIVGO,
    ST_DIV,
    ST_DECAY,
    ST_DONE
  } tlt_state_e;

  tlt_state_e          state_q;
  logic [FACTOR_W-1:0] factor_q;
  logic [SCALE_W-1:0]  scale_q;
  logic [TIME_W-1:0]   run_q, idle_q, last_q, now_q;
  logic [RS_W-1:0]     cur_rs_q, new_rs_q;
  logic [REQ_W-1:0]    req_q;
  logic [LOAD_W-1:0]   load_q;
  logic                run_sel_q, err_q;
  logic                out_valid_q, time_error_q;
  logic [LOAD_W-1:0]   load_level_q;

  logic                accept;
  logic                acct_start, div_start, decay_start;
  acct_res_t           acct_res;
  logic                div_done, decay_done;
  logic [LOAD_W-1:0]   div_load;
  logic [TIME_W-1:0]   decay_run, decay_idle, acct_acc;
  logic                is_runnable;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign is_runnable = (cur_rs_q <= RS_DEFERRED);
  assign acct_acc    = is_runnable ? run_q : idle_q;
  assign acct_start  = accept && (req_type_i == REQ_STATE || req_type_i == REQ_UPDATE);
  assign decay_start = accept && (req_type_i == REQ_DECAY);
  assign div_start   = (state_q == ST_DIVGO);

  // Serial accounting of the time since the last stamp.
  tlt_acct u_acct (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (acct_start),
    .now_i   (timestamp_i),
    .last_i  (last_q),
    .acc_i   (acct_acc),
    .res_o   (acct_res)
  );

  // Load ratio divider.
  tlt_div #(
    .LOAD_SHIFT (LOAD_SHIFT)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .run_i   (run_q),
    .idle_i  (idle_q),
    .done_o  (div_done),
    .load_o  (div_load)
  );

  // Accumulator decay.
  tlt_decay u_decay (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (decay_start),
    .run_i    (run_q),
    .idle_i   (idle_q),
    .factor_i (factor_q),
    .scale_i  (scale_q),
    .done_o   (decay_done),
    .run_o    (decay_run),
    .idle_o   (decay_idle)
  );

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FACTOR_W'(1);
      scale_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DECAY_FACTOR: factor_q <= cfg_data_i[FACTOR_W-1:0];
        CFG_DECAY_SCALE:  scale_q  <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Request sequencer, tracker state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= '0;
      idle_q      <= '0;
      last_q      <= '0;
      cur_rs_q    <= RS_INTERRUPTED;
      load_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A finished result enters the output register once it is free.
      if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (acct_start) begin
              state_q <= ST_ACCT;
            end else if (decay_start) begin
              state_q <= ST_DECAY;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_ACCT: begin
          if (acct_res.done) begin
            if (!acct_res.err) begin
              last_q <= now_q;
              if (run_sel_q) begin
                run_q <= acct_res.acc;
              end else begin
                idle_q <= acct_res.acc;
              end
            end
            if (req_q == REQ_STATE) begin
              cur_rs_q <= new_rs_q;
              state_q  <= ST_DONE;
            end else begin
              state_q <= ST_DIVGO;
            end
          end
        end
        ST_DIVGO: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            load_q  <= div_load;
            state_q <= ST_DONE;
          end
        end
        ST_DECAY: begin
          if (decay_done) begin
            run_q   <= decay_run;
            idle_q  <= decay_idle;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Item fields and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= req_type_i;
      now_q     <= timestamp_i;
      new_rs_q  <= run_state_i;
      run_sel_q <= is_runnable;
      err_q     <= 1'b0;
    end
    if (state_q == ST_ACCT && acct_res.done) begin
      err_q <= acct_res.err;
    end
    if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
      load_level_q <= load_q;
      time_error_q <= err_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign load_level_o = load_level_q;
  assign time_error_o = time_error_q;

  // The accounting unit reports only while an accounting pass is awaited.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acct_res.done |-> state_q == ST_ACCT)
    else $error("accounting result outside the accounting phase");

  // The divider reports only while a load update is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider result outside the division phase");

  // An accepted item keeps the input closed on the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second item accepted while one is in progress");

  // A load fraction never exceeds one, scaled, nor the field's range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(load_level_o) <= LOAD_LIMIT))
    else $error("load level above its limit");

endmodule

// ===== tb/thread_load_tracker_test.sv =====
// Self-checking testbench for the thread load tracker: predicts every result item and compares.
module thread_load_tracker_test;
  import tlt_pkg::*;

  // Request and run state codes that the package does not name.
  localparam logic [REQ_W-1:0] REQ_NONE        = 2'd3;
  localparam logic [RS_W-1:0]  RS_ACTIVE       = 3'd0;
  localparam logic [RS_W-1:0]  RS_SUSPENDED    = 3'd1;
  localparam logic [RS_W-1:0]  RS_BLOCKED      = 3'd3;
  localparam logic [RS_W-1:0]  RS_INTR_BLOCKED = 3'd4;
  localparam logic [RS_W-1:0]  RS_TERMINATED   = 3'd6;
  localparam logic [RS_W-1:0]  RS_UNUSED       = 3'd7;
  // Register indexes that the block has no register for.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [TIME_W-1:0]    STAMP_MAX   = '1;
  localparam int unsigned          SHIFT       = LOAD_SHIFT_DEF;

  typedef struct {
    logic [REQ_W-1:0]  kind;
    logic [TIME_W-1:0] stamp;
    logic [RS_W-1:0]   rs;
    bit                drain;
  } request_t;

  typedef struct packed {
    logic [LOAD_W-1:0] load;
    logic              err;
  } load_result_t;

  logic                  clk_i;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic [REQ_W-1:0]      req_type_i   = '0;
  logic [TIME_W-1:0]     timestamp_i  = '0;
  logic [RS_W-1:0]       run_state_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic [LOAD_W-1:0]     load_level_o;
  logic                  time_error_o;

  thread_load_tracker #(.LOAD_SHIFT(SHIFT)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .timestamp_i  (timestamp_i),
    .run_state_i  (run_state_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .load_level_o (load_level_o),
    .time_error_o (time_error_o)
  );

  // Predicted tracker state and configuration.
  logic [TIME_W-1:0]   runnable_acc = '0;
  logic [TIME_W-1:0]   idle_acc     = '0;
  logic [TIME_W-1:0]   last_stamp   = '0;
  logic [RS_W-1:0]     cur_state    = RS_INTERRUPTED;
  logic [LOAD_W-1:0]   cur_load     = '0;
  logic [FACTOR_W-1:0] decay_factor = 32'd1;
  logic [SCALE_W-1:0]  decay_scale  = '0;

  request_t          request_q[$];
  load_result_t      load_exp_q[$];
  request_t          cur_req;
  bit                sending       = 1'b0;
  bit                no_idle       = 1'b0;
  int unsigned       send_gap      = 0;
  int unsigned       recv_stall    = 0;
  int unsigned       requests_sent = 0;
  int unsigned       results_seen  = 0;
  int unsigned       errors        = 0;
  logic [TIME_W-1:0] stamp_cursor  = '0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_wait();
    return no_idle ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_W] ? STAMP_MAX : sum[TIME_W-1:0];
  endfunction

  // Applies one item to the predicted state and returns the result it should produce.
  function automatic load_result_t step_tracker(request_t r);
    load_result_t      res;
    logic [127:0]      quo;
    logic [TIME_W-1:0] prod;
    res.err = 1'b0;
    if (r.kind == REQ_STATE || r.kind == REQ_UPDATE) begin
      // A stamp that goes backwards accounts nothing and keeps the later stamp.
      if (r.stamp < last_stamp) begin
        res.err = 1'b1;
      end else begin
        if (cur_state <= RS_DEFERRED) begin
          runnable_acc = sat_add(runnable_acc, r.stamp - last_stamp);
        end else begin
          idle_acc = sat_add(idle_acc, r.stamp - last_stamp);
        end
        last_stamp = r.stamp;
      end
      if (r.kind == REQ_STATE) begin
        cur_state = r.rs;
      end else if (runnable_acc == '0) begin
        cur_load = '0;
      end else begin
        // The sum is taken at full width so that it cannot wrap.
        quo = (128'(runnable_acc) << SHIFT) / (128'(runnable_acc) + 128'(idle_acc));
        cur_load = (quo > LOAD_MAX) ? LOAD_W'(LOAD_MAX) : quo[LOAD_W-1:0];
      end
    end else if (r.kind == REQ_DECAY) begin
      prod = runnable_acc * TIME_W'(decay_factor);
      runnable_acc = prod >> decay_scale;
      prod = idle_acc * TIME_W'(decay_factor);
      idle_acc = prod >> decay_scale;
    end
    res.load = cur_load;
    return res;
  endfunction

  // Request driver: presents queued items, predicting each one as it is accepted.
  always @(posedge clk_i) begin : request_driver
    if (rst_ni) begin
      if (sending && in_ready_o) begin
        load_exp_q.insert(load_exp_q.size(), step_tracker(cur_req));
        requests_sent++;
        sending = 1'b0;
      end
      if (!sending) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (request_q.size() != 0 &&
                     (!request_q[0].drain || requests_sent == results_seen)) begin
          cur_req  = request_q[0];
          request_q.delete(0);
          sending  = 1'b1;
          send_gap = pick_wait();
        end
      end
      in_valid_i  <= sending;
      req_type_i  <= cur_req.kind;
      timestamp_i <= cur_req.stamp;
      run_state_i <= cur_req.rs;
    end
  end

  // Result monitor: stalls at random and checks each item against the oldest prediction.
  always @(posedge clk_i) begin : result_monitor
    load_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        if (load_exp_q.size() == 0) begin
          $error("result item with no prediction waiting: load_level %0d time_error %0d",
                 load_level_o, time_error_o);
          errors++;
        end else begin
          want = load_exp_q[0];
          load_exp_q.delete(0);
          if (load_level_o !== want.load) begin
            $error("load_level: expected %0d, actual %0d", want.load, load_level_o);
            errors++;
          end
          if (time_error_o !== want.err) begin
            $error("time_error: expected %0d, actual %0d", want.err, time_error_o);
            errors++;
          end
        end
        recv_stall = pick_wait();
      end else if (out_valid_o && recv_stall != 0) begin
        recv_stall--;
      end
      out_ready_i <= (recv_stall == 0);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_DECAY_FACTOR) begin
      decay_factor = data;
    end else if (idx == CFG_DECAY_SCALE) begin
      decay_scale = data[SCALE_W-1:0];
    end
  endtask

  task automatic queue_request(input logic [REQ_W-1:0] kind, input logic [TIME_W-1:0] stamp,
                               input logic [RS_W-1:0] rs);
    request_t r;
    r.kind  = kind;
    r.stamp = stamp;
    r.rs    = rs;
    r.drain = 1'b0;
    request_q.insert(request_q.size(), r);
  endtask

  // Waits until every item has been sent and answered, then lets the block settle.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (request_q.size() != 0 || sending || requests_sent != results_seen);
    repeat (4) @(negedge clk_i);
  endtask

  // Random items: mostly rising stamps, with some repeated and some going backwards.
  // With wide set, long gaps reach far up the timestamp range.
  task automatic queue_random_requests(input int count, input bit wide);
    request_t    r;
    int unsigned pick;
    int unsigned back;
    repeat (count) begin
      pick    = $urandom_range(0, 99);
      r.stamp = {$urandom, $urandom};
      r.rs    = RS_W'($urandom_range(0, 7));
      r.drain = ($urandom_range(0, 99) == 0);
      if (pick < 55) begin
        r.kind = REQ_STATE;
      end else if (pick < 80) begin
        r.kind = REQ_UPDATE;
      end else if (pick < 96) begin
        r.kind = REQ_DECAY;
      end else begin
        r.kind = REQ_NONE;
      end
      if (r.kind == REQ_STATE || r.kind == REQ_UPDATE) begin
        pick = $urandom_range(0, 99);
        back = $urandom_range(1, 4096);
        if (pick < 8) begin
          r.stamp = (stamp_cursor > back) ? stamp_cursor - back : '0;
        end else if (pick < 14) begin
          r.stamp = stamp_cursor;
        end else if (pick < (wide ? 60 : 19)) begin
          r.stamp = stamp_cursor + (wide ? {8'b0, 24'($urandom), 32'($urandom)}
                                         : TIME_W'($urandom));
        end else begin
          r.stamp = stamp_cursor + TIME_W'($urandom_range(1, 1 << 20));
        end
        if (r.stamp > stamp_cursor) stamp_cursor = r.stamp;
      end
      request_q.insert(request_q.size(), r);
    end
  endtask

  task automatic run_phase(input logic [FACTOR_W-1:0] factor, input logic [SCALE_W-1:0] scale,
                           input int count, input bit quiet, input bit wide);
    write_reg(CFG_DECAY_FACTOR, factor);
    write_reg(CFG_DECAY_SCALE, ($urandom & ~32'h3F) | CFG_DATA_W'(scale));
    no_idle = quiet;
    queue_random_requests(count, wide);
    wait_idle();
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items under the reset configuration: every run state, both error
    // paths, zero elapsed time, full load, ignored fields and the unknown request.
    queue_request(REQ_UPDATE, 64'd0, RS_ACTIVE);
    queue_request(REQ_STATE, 64'd0, RS_ACTIVE);
    queue_request(REQ_UPDATE, 64'd64, RS_ACTIVE);
    queue_request(REQ_STATE, 64'd100, RS_SUSPENDED);
    queue_request(REQ_STATE, 64'd200, RS_DEFERRED);
    queue_request(REQ_STATE, 64'd300, RS_BLOCKED);
    queue_request(REQ_STATE, 64'd400, RS_INTR_BLOCKED);
    queue_request(REQ_STATE, 64'd500, RS_INTERRUPTED);
    queue_request(REQ_STATE, 64'd600, RS_TERMINATED);
    queue_request(REQ_STATE, 64'd700, RS_UNUSED);
    queue_request(REQ_UPDATE, 64'd800, RS_ACTIVE);
    queue_request(REQ_STATE, 64'd750, RS_ACTIVE);
    queue_request(REQ_UPDATE, 64'd790, RS_ACTIVE);
    queue_request(REQ_UPDATE, 64'd800, RS_ACTIVE);
    queue_request(REQ_DECAY, STAMP_MAX, RS_UNUSED);
    queue_request(REQ_NONE, STAMP_MAX, RS_UNUSED);
    queue_request(REQ_NONE, 64'd0, RS_ACTIVE);
    queue_request(REQ_UPDATE, 64'd1000, RS_ACTIVE);
    queue_request(REQ_DECAY, 64'd0, RS_ACTIVE);
    stamp_cursor = 64'd1000;
    wait_idle();

    // Random phases, each under its own decay setting.
    run_phase(32'd3, 6'd2, 400, 1'b0, 1'b0);
    run_phase(32'hFFFF_FFFF, 6'd63, 300, 1'b1, 1'b0);
    run_phase($urandom, 6'($urandom_range(0, 8)), 400, 1'b0, 1'b0);
    // Writes to indexes without a register must change nothing.
    write_reg(CFG_SPARE_A, $urandom);
    write_reg(CFG_SPARE_B, $urandom);
    run_phase(32'd1, 6'd1, 300, 1'b0, 1'b0);
    run_phase(32'd0, 6'd0, 200, 1'b0, 1'b0);
    run_phase(32'd7, 6'd3, 40, 1'b0, 1'b1);

    // Extremes: wrapped accumulators, a saturating add and the largest stamp.
    write_reg(CFG_DECAY_FACTOR, 32'hFFFF_FFFF);
    write_reg(CFG_DECAY_SCALE, 32'hFFFF_FFC0);
    queue_request(REQ_DECAY, 64'd0, RS_ACTIVE);
    queue_request(REQ_DECAY, 64'd0, RS_ACTIVE);
    queue_request(REQ_STATE, stamp_cursor, RS_ACTIVE);
    queue_request(REQ_UPDATE, STAMP_MAX, RS_ACTIVE);
    queue_request(REQ_STATE, STAMP_MAX, RS_BLOCKED);
    queue_request(REQ_UPDATE, STAMP_MAX, RS_ACTIVE);
    queue_request(REQ_UPDATE, STAMP_MAX - 1, RS_ACTIVE);
    queue_request(REQ_DECAY, 64'd0, RS_ACTIVE);
    queue_request(REQ_UPDATE, STAMP_MAX, RS_ACTIVE);
    wait_idle();

    // A zero factor with the largest shift clears both accumulators.
    write_reg(CFG_DECAY_FACTOR, 32'd0);
    write_reg(CFG_DECAY_SCALE, 32'hFFFF_FFFF);
    queue_request(REQ_DECAY, STAMP_MAX, RS_UNUSED);
    queue_request(REQ_UPDATE, STAMP_MAX, RS_ACTIVE);
    queue_request(REQ_STATE, 64'd0, RS_ACTIVE);
    queue_request(REQ_UPDATE, 64'd5, RS_ACTIVE);
    wait_idle();

    repeat (20) @(posedge clk_i);
    if (load_exp_q.size() != 0) begin
      $error("%0d predicted result items never arrived", load_exp_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tlt_pkg.sv
rtl/tlt_acct.sv
rtl/tlt_div.sv
rtl/tlt_decay.sv
rtl/thread_load_tracker.sv
tb/thread_load_tracker_test.sv
